// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the adjoint accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define RFIGA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RFIGA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rfiga_pkg.sv =====
// Types, constants and helper functions of the adjoint accumulator.
package rfiga_pkg;

  localparam int unsigned WIDE = 64;
  localparam int unsigned CW = 34;
  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032875;
  localparam logic signed [WIDE-1:0] S64_MAX = {1'b0, {(WIDE-1){1'b1}}};
  localparam logic signed [WIDE-1:0] S64_MIN = {1'b1, {(WIDE-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_ROT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_PH_ACC,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_PRE_A,
    OP_PRE_B,
    OP_PIM_A,
    OP_PIM_B,
    OP_TRE_A,
    OP_TRE_B,
    OP_TIM_A,
    OP_TIM_B,
    OP_PH_A,
    OP_PH_B,
    OP_SCL_RE,
    OP_SCL_IM,
    OP_SCL_PH
  } op_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic start;
    logic sh30;
  } mul_req_t;

  // Arctangent of 2^-i as a fraction of a turn, 32-bit scale.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335086;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Saturating 64-bit signed add.
  function automatic logic signed [WIDE-1:0] sat_add(input logic signed [WIDE-1:0] a,
                                                     input logic signed [WIDE-1:0] b);
    logic signed [WIDE-1:0] s;
    s = a + b;
    if (a[WIDE-1] == b[WIDE-1] && s[WIDE-1] != a[WIDE-1]) begin
      s = a[WIDE-1] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  // Saturating 64-bit signed negation.
  function automatic logic signed [WIDE-1:0] sat_neg(input logic signed [WIDE-1:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

endpackage

// ===== src/rfi_gain_phase_adjoint_accumulator_core.sv =====
// Top level of the gain and phase adjoint accumulator: sequencer, CORDIC, sums.
// A word with a term runs the CORDIC loop, a rotation step and ten passes through the shared
// multiplier, then adds its phase term; a last word then also scales the three sums and emits.
// A word without a term and not last leaves the sequencer idle; one without a term but last goes straight to scaling.
// The block takes one word at a time; a finished word waits in the output register.
// Synchronous active-low reset clears the sums, sets inv_count to 65536 and empties the output.
`include "assert_macros.svh"

module rfi_gain_phase_adjoint_accumulator_core #(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic                           in_term_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] in_my_amp_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_my_amp_im,
  input  logic [31:0]                    in_my_phase,
  input  logic signed [SAMPLE_WIDTH-1:0] in_other_amp_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_other_amp_im,
  input  logic [31:0]                    in_other_phase,
  input  logic signed [SAMPLE_WIDTH-1:0] in_vis_grad_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_vis_grad_im,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_amp_grad_re,
  output logic signed [SAMPLE_WIDTH-1:0] out_amp_grad_im,
  output logic signed [SAMPLE_WIDTH-1:0] out_phase_grad,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [1:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int W = rfiga_pkg::WIDE;
  localparam int CNTW = $clog2(CORDIC_STAGES) + 1;
  localparam logic [CNTW-1:0] LAST_STAGE = CNTW'(CORDIC_STAGES - 1);
  localparam logic signed [W-1:0] SW_MAX = W'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [W-1:0] SW_MIN = -SW_MAX - 64'sd1;

  rfiga_pkg::state_t state_r, state_nxt;
  rfiga_pkg::op_t    op_r, op_nxt;

  logic [16:0] inv_count_r;

  // Latched input word.
  logic                 second_r, last_r;
  logic signed [W-1:0]  mre_r, mim_r, ore_r, oim_r, gre_r, gim_r;

  // CORDIC state.
  logic [CNTW-1:0]                     cnt_r, cnt_nxt;
  logic [1:0]                          quad_r, quad_nxt;
  logic signed [rfiga_pkg::CW-1:0]     x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [rfiga_pkg::CW-1:0]     c_r, c_nxt, s_r, s_nxt;

  // Intermediates and sums.
  logic signed [W-1:0] t0_r, t0_nxt, pre_r, pre_nxt, pim_r, pim_nxt;
  logic signed [W-1:0] tre_r, tre_nxt, tim_r, tim_nxt, ph_r, ph_nxt;
  logic signed [W-1:0] sum_re_r, sum_re_nxt, sum_im_r, sum_im_nxt, sum_ph_r, sum_ph_nxt;
  logic signed [SW-1:0] res_re_r, res_re_nxt, res_im_r, res_im_nxt, res_ph_r;
  logic signed [SW-1:0] out_re_r, out_im_r, out_ph_r;
  logic                 out_valid_r, out_valid_nxt;

  // Shared multiplier connection.
  rfiga_pkg::mul_req_t  mreq;
  logic signed [W-1:0]  mul_a, mul_b, mul_res;
  logic                 mul_done;

  logic                 accept, cfg_wr, emit_go;
  logic [31:0]          d_in, rot_ang;
  logic signed [rfiga_pkg::CW-1:0] dx, dy, atan_ext;
  logic signed [W-1:0]  comb_t, comb_neg, sat_in;
  logic signed [SW-1:0] sat_out;

  assign accept  = in_valid && !in_stall;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign emit_go = (state_r == rfiga_pkg::ST_EMIT) && (!out_valid_r || !out_stall);
  assign d_in    = in_req_type ? (in_other_phase - in_my_phase) : (in_my_phase - in_other_phase);
  assign rot_ang = d_in + 32'h2000_0000;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_count_r <= 17'd65536;
    end else if (cfg_wr && paddr == 2'd0) begin
      inv_count_r <= pwdata[16:0];
    end
  end

  assign prdata = (paddr == 2'd0) ? {15'd0, inv_count_r} : 32'd0;
  assign pready = 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rfiga_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_term_valid) begin
            state_nxt = rfiga_pkg::ST_CORDIC;
          end else if (in_last) begin
            state_nxt = rfiga_pkg::ST_MUL_GO;
          end
        end
      end
      rfiga_pkg::ST_CORDIC: begin
        if (cnt_r == LAST_STAGE) begin
          state_nxt = rfiga_pkg::ST_ROT;
        end
      end
      rfiga_pkg::ST_ROT:    state_nxt = rfiga_pkg::ST_MUL_GO;
      rfiga_pkg::ST_MUL_GO: state_nxt = rfiga_pkg::ST_MUL_WAIT;
      rfiga_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          case (op_r)
            rfiga_pkg::OP_PH_B:    state_nxt = rfiga_pkg::ST_PH_ACC;
            rfiga_pkg::OP_SCL_PH:  state_nxt = rfiga_pkg::ST_EMIT;
            default:               state_nxt = rfiga_pkg::ST_MUL_GO;
          endcase
        end
      end
      rfiga_pkg::ST_PH_ACC: begin
        state_nxt = last_r ? rfiga_pkg::ST_MUL_GO : rfiga_pkg::ST_IDLE;
      end
      rfiga_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = rfiga_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rfiga_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the multiplier.
  always_comb begin
    mreq.start = (state_r == rfiga_pkg::ST_MUL_GO);
    mreq.sh30  = 1'b0;
    case (op_r)
      rfiga_pkg::OP_PRE_A: begin mul_a = gre_r; mul_b = ore_r; end
      rfiga_pkg::OP_PRE_B: begin mul_a = gim_r; mul_b = oim_r; end
      rfiga_pkg::OP_PIM_A: begin
        mul_a = second_r ? gre_r : gim_r;
        mul_b = second_r ? oim_r : ore_r;
      end
      rfiga_pkg::OP_PIM_B: begin
        mul_a = second_r ? gim_r : gre_r;
        mul_b = second_r ? ore_r : oim_r;
      end
      rfiga_pkg::OP_TRE_A: begin mul_a = pre_r; mul_b = W'(c_r); mreq.sh30 = 1'b1; end
      rfiga_pkg::OP_TRE_B: begin mul_a = pim_r; mul_b = W'(s_r); mreq.sh30 = 1'b1; end
      rfiga_pkg::OP_TIM_A: begin mul_a = pre_r; mul_b = W'(s_r); mreq.sh30 = 1'b1; end
      rfiga_pkg::OP_TIM_B: begin mul_a = pim_r; mul_b = W'(c_r); mreq.sh30 = 1'b1; end
      rfiga_pkg::OP_PH_A:  begin mul_a = tim_r; mul_b = mre_r; end
      rfiga_pkg::OP_PH_B:  begin mul_a = tre_r; mul_b = mim_r; end
      rfiga_pkg::OP_SCL_RE: begin mul_a = sum_re_r; mul_b = {47'd0, inv_count_r}; end
      rfiga_pkg::OP_SCL_IM: begin mul_a = sum_im_r; mul_b = {47'd0, inv_count_r}; end
      default:              begin mul_a = sum_ph_r; mul_b = {47'd0, inv_count_r}; end
    endcase
  end

  rfiga_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mreq),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  // CORDIC step terms.
  always_comb begin
    dx = y_r >>> cnt_r[4:0];
    dy = x_r >>> cnt_r[4:0];
    atan_ext = {2'b00, rfiga_pkg::atan_turn(cnt_r[4:0])};
  end

  // Combining a product with the held one; saturation to the sample width.
  always_comb begin
    comb_neg = rfiga_pkg::sat_neg(mul_res);
    case (op_r)
      rfiga_pkg::OP_PRE_B: comb_t = rfiga_pkg::sat_add(t0_r, second_r ? comb_neg : mul_res);
      rfiga_pkg::OP_PIM_B: comb_t = rfiga_pkg::sat_add(t0_r, second_r ? mul_res : comb_neg);
      rfiga_pkg::OP_TRE_B: comb_t = rfiga_pkg::sat_add(t0_r, comb_neg);
      default:             comb_t = rfiga_pkg::sat_add(t0_r, mul_res);
    endcase
    sat_in = mul_res;
    if (!sat_in[W-1] && (|sat_in[W-2:SW-1])) begin
      sat_out = SW_MAX[SW-1:0];
    end else if (sat_in[W-1] && !(&sat_in[W-2:SW-1])) begin
      sat_out = SW_MIN[SW-1:0];
    end else begin
      sat_out = sat_in[SW-1:0];
    end
  end

  // Datapath updates.
  always_comb begin
    op_nxt     = op_r;
    cnt_nxt    = cnt_r;
    quad_nxt   = quad_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    c_nxt      = c_r;
    s_nxt      = s_r;
    t0_nxt     = t0_r;
    pre_nxt    = pre_r;
    pim_nxt    = pim_r;
    tre_nxt    = tre_r;
    tim_nxt    = tim_r;
    ph_nxt     = ph_r;
    sum_re_nxt = sum_re_r;
    sum_im_nxt = sum_im_r;
    sum_ph_nxt = sum_ph_r;
    res_re_nxt = res_re_r;
    res_im_nxt = res_im_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      rfiga_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_nxt  = '0;
          quad_nxt = rot_ang[31:30];
          x_nxt    = rfiga_pkg::CORDIC_K;
          y_nxt    = '0;
          z_nxt    = rfiga_pkg::CW'($signed(d_in - {rot_ang[31:30], 30'd0}));
          op_nxt   = in_term_valid ? rfiga_pkg::OP_PRE_A : rfiga_pkg::OP_SCL_RE;
        end
      end
      rfiga_pkg::ST_CORDIC: begin
        if (!z_r[rfiga_pkg::CW-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_ext;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_ext;
        end
        cnt_nxt = cnt_r + CNTW'(1);
      end
      rfiga_pkg::ST_ROT: begin
        case (quad_r)
          2'd0:    begin c_nxt = x_r;  s_nxt = y_r;  end
          2'd1:    begin c_nxt = -y_r; s_nxt = x_r;  end
          2'd2:    begin c_nxt = -x_r; s_nxt = -y_r; end
          default: begin c_nxt = y_r;  s_nxt = -x_r; end
        endcase
      end
      rfiga_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          op_nxt = rfiga_pkg::op_t'(op_r + 4'd1);
          case (op_r)
            rfiga_pkg::OP_PRE_B: pre_nxt = comb_t;
            rfiga_pkg::OP_PIM_B: pim_nxt = comb_t;
            rfiga_pkg::OP_TRE_B: tre_nxt = comb_t;
            rfiga_pkg::OP_TIM_B: begin
              tim_nxt    = second_r ? rfiga_pkg::sat_neg(comb_t) : comb_t;
              sum_re_nxt = rfiga_pkg::sat_add(sum_re_r, tre_r);
            end
            rfiga_pkg::OP_PH_A: begin
              t0_nxt     = mul_res;
              sum_im_nxt = rfiga_pkg::sat_add(sum_im_r, tim_r);
            end
            rfiga_pkg::OP_PH_B:   ph_nxt = rfiga_pkg::sat_neg(comb_t);
            rfiga_pkg::OP_SCL_RE: res_re_nxt = sat_out;
            rfiga_pkg::OP_SCL_IM: res_im_nxt = sat_out;
            rfiga_pkg::OP_SCL_PH: op_nxt = rfiga_pkg::OP_PRE_A;
            default:              t0_nxt = mul_res;
          endcase
        end
      end
      rfiga_pkg::ST_PH_ACC: begin
        sum_ph_nxt = rfiga_pkg::sat_add(sum_ph_r, ph_r);
        op_nxt     = rfiga_pkg::OP_SCL_RE;
      end
      rfiga_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          sum_re_nxt    = '0;
          sum_im_nxt    = '0;
          sum_ph_nxt    = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers and sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfiga_pkg::ST_IDLE;
      op_r        <= rfiga_pkg::OP_PRE_A;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sum_re_r    <= '0;
      sum_im_r    <= '0;
      sum_ph_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sum_re_r    <= sum_re_nxt;
      sum_im_r    <= sum_im_nxt;
      sum_ph_r    <= sum_ph_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      second_r <= in_req_type;
      last_r   <= in_last;
      mre_r    <= W'(in_my_amp_re);
      mim_r    <= W'(in_my_amp_im);
      ore_r    <= W'(in_other_amp_re);
      oim_r    <= W'(in_other_amp_im);
      gre_r    <= W'(in_vis_grad_re);
      gim_r    <= W'(in_vis_grad_im);
    end
    quad_r   <= quad_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    c_r      <= c_nxt;
    s_r      <= s_nxt;
    t0_r     <= t0_nxt;
    pre_r    <= pre_nxt;
    pim_r    <= pim_nxt;
    tre_r    <= tre_nxt;
    tim_r    <= tim_nxt;
    ph_r     <= ph_nxt;
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    if (state_r == rfiga_pkg::ST_MUL_WAIT && mul_done && op_r == rfiga_pkg::OP_SCL_PH) begin
      res_ph_r <= sat_out;
    end
    if (emit_go) begin
      out_re_r <= res_re_r;
      out_im_r <= res_im_r;
      out_ph_r <= res_ph_r;
    end
  end

  assign in_stall        = (state_r != rfiga_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_amp_grad_re = out_re_r;
  assign out_amp_grad_im = out_im_r;
  assign out_phase_grad  = out_ph_r;

  // A new result word appears only out of the emit step.
  `RFIGA_ASSERT(a_out_from_emit, $rose(out_valid_r) |-> $past(state_r) == rfiga_pkg::ST_EMIT, "result word without emit step")
  // The multiplier reports completion only while the sequencer waits for it.
  `RFIGA_ASSERT(a_mul_done_wait, mul_done |-> state_r == rfiga_pkg::ST_MUL_WAIT, "multiplier done outside wait")
  // Emitting a result clears all three sums.
  `RFIGA_ASSERT(a_emit_clears, emit_go |=> (sum_re_r == '0 && sum_im_r == '0 && sum_ph_r == '0), "sums not cleared after emit")

endmodule

// ===== src/rfiga_mul.sv =====
// Shared multiplier: exact 64x64 product in four 32x32 steps, floor shift, saturation.
module rfiga_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rfiga_pkg::mul_req_t                   req,
  input  logic signed [rfiga_pkg::WIDE-1:0]     op_a,
  input  logic signed [rfiga_pkg::WIDE-1:0]     op_b,
  output logic                                  done,
  output logic signed [rfiga_pkg::WIDE-1:0]     result
);

  logic [63:0]  ua_r, ua_nxt;
  logic [63:0]  ub_r, ub_nxt;
  logic         neg_r, neg_nxt;
  logic         sh30_r, sh30_nxt;
  logic [1:0]   k_r, k_nxt;
  logic         busy_r, busy_nxt;
  logic         fin_r, fin_nxt;
  logic         done_r, done_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic signed [63:0] res_r, res_nxt;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_shift;
  logic [112:0] q;
  logic         rem;

  // One partial product per cycle, low halves first.
  always_comb begin
    a_half = k_r[1] ? ua_r[63:32] : ua_r[31:0];
    b_half = k_r[0] ? ub_r[63:32] : ub_r[31:0];
    pp = {32'd0, a_half} * {32'd0, b_half};
    case ({k_r[1], k_r[0]})
      2'b00:   pp_shift = {64'd0, pp};
      2'b11:   pp_shift = {pp, 64'd0};
      default: pp_shift = {32'd0, pp, 32'd0};
    endcase
  end

  // Floor shift of the magnitude, rounding away from zero for negative results.
  always_comb begin
    if (sh30_r) begin
      q = {15'd0, acc_r[127:30]};
      rem = |acc_r[29:0];
    end else begin
      q = {1'b0, acc_r[127:16]};
      rem = |acc_r[15:0];
    end
    q = q + {112'd0, (neg_r & rem)};
    if (!neg_r) begin
      res_nxt = (|q[112:63]) ? rfiga_pkg::S64_MAX : $signed(q[63:0]);
    end else begin
      res_nxt = ((|q[112:64]) || q[63]) ? rfiga_pkg::S64_MIN : -$signed(q[63:0]);
    end
  end

  // Sequencing of the four partial products and the final step.
  always_comb begin
    ua_nxt   = ua_r;
    ub_nxt   = ub_r;
    neg_nxt  = neg_r;
    sh30_nxt = sh30_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    if (req.start) begin
      ua_nxt   = op_a[63] ? (64'd0 - op_a) : op_a;
      ub_nxt   = op_b[63] ? (64'd0 - op_b) : op_b;
      neg_nxt  = op_a[63] ^ op_b[63];
      sh30_nxt = req.sh30;
      k_nxt    = 2'd0;
      busy_nxt = 1'b1;
      acc_nxt  = 128'd0;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp_shift;
      k_nxt   = k_r + 2'd1;
      if (k_r == 2'd3) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
    if (fin_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ua_r   <= ua_nxt;
    ub_r   <= ub_nxt;
    neg_r  <= neg_nxt;
    sh30_r <= sh30_nxt;
    acc_r  <= acc_nxt;
    if (fin_r) begin
      res_r <= res_nxt;
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
